FILE: src/bbqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbqr_pkg: shared types, constants and character tables
// Command record between front and back, register indexes, alphabets.
// ----------------------------------------------------------------------------
package bbqr_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned PartW    = 11;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENCODING    = 2'd0,
    CFG_FILE_TYPE   = 2'd1,
    CFG_PART_TOTAL  = 2'd2,
    CFG_PART_NUMBER = 2'd3
  } cfg_idx_e;

  localparam logic [CodeW-1:0] EncodingReset = 8'd50;
  localparam logic [CodeW-1:0] FileTypeReset = 8'd85;
  localparam logic [PartW-1:0] TotalReset    = 11'd1;
  localparam logic [PartW-1:0] NumberReset   = 11'd0;
  localparam logic [PartW-1:0] MaxTwoDigit   = 11'd1295;

  localparam logic [7:0] CharB      = 8'h42;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharA      = 8'h41;
  localparam logic [7:0] CharTwo    = 8'h32;

  // Output slot positions within one command: header 0..7, payload 8..10.
  localparam logic [3:0] PosB        = 4'd0;
  localparam logic [3:0] PosDollar   = 4'd1;
  localparam logic [3:0] PosEncoding = 4'd2;
  localparam logic [3:0] PosFileType = 4'd3;
  localparam logic [3:0] PosTotalHi  = 4'd4;
  localparam logic [3:0] PosTotalLo  = 4'd5;
  localparam logic [3:0] PosNumberHi = 4'd6;
  localparam logic [3:0] PosNumberLo = 4'd7;
  localparam logic [3:0] PosPay0     = 4'd8;
  localparam logic [3:0] PosPay1     = 4'd9;
  localparam logic [3:0] PosPay2     = 4'd10;

  // floor(v / 36) == (v * Recip36) >> Recip36Shift for v up to 1295
  localparam logic [PartW-1:0] Recip36      = 11'd1821;
  localparam int unsigned      Recip36Shift = 16;
  localparam logic [PartW-1:0] Base36       = 11'd36;

  typedef struct packed {
    logic            err;       // invalid numbering: one error result
    logic            hdr;       // emit the 8-character header first
    logic            hdr_last;  // header ends the part
    logic [1:0]      n_pay;     // base32 characters after the header, 0..3
    logic [2:0][4:0] pay;       // base32 symbol indexes
    logic            pay_last;  // last payload character ends the part
  } cmd_t;

  function automatic logic [7:0] b32_char(input logic [4:0] sym);
    logic [7:0] s;
    s = {3'b000, sym};
    if (sym < 5'd26) begin
      return CharA + s;
    end else begin
      return CharTwo + s - 8'd26;
    end
  endfunction

  function automatic logic [7:0] b36_char(input logic [5:0] dig);
    logic [7:0] d;
    d = {2'b00, dig};
    if (dig < 6'd10) begin
      return CharZero + d;
    end else begin
      return CharA + d - 8'd10;
    end
  endfunction

endpackage

FILE: src/bbqr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbqr_in_if: payload byte channel
// Valid/ready channel carrying one raw byte with end-of-part marks.
// ----------------------------------------------------------------------------
interface bbqr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_part;

  modport source (output valid, data_byte, last_byte, empty_part, input ready);
  modport sink   (input valid, data_byte, last_byte, empty_part, output ready);
endinterface

FILE: src/bbqr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbqr_out_if: framed character channel
// Valid/ready channel carrying one ASCII character with end and error marks.
// ----------------------------------------------------------------------------
interface bbqr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  logic       error;

  modport source (output valid, out_char, last_char, error, input ready);
  modport sink   (input valid, out_char, last_char, error, output ready);
endinterface

FILE: src/bbqr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbqr_front: item classifier
// Checks numbering, tracks header and leftover bits, builds one command.
// ----------------------------------------------------------------------------
module bbqr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  input  logic                          empty_part_i,
  input  logic [bbqr_pkg::PartW-1:0]    part_total_i,
  input  logic [bbqr_pkg::PartW-1:0]    part_number_i,
  output logic                          push_o,
  output bbqr_pkg::cmd_t                cmd_o
);

  logic       hdr_done_q, hdr_done_d;
  logic [3:0] lo_bits_q, lo_bits_d;
  logic [2:0] lo_cnt_q, lo_cnt_d;

  logic        cfg_bad;
  logic [11:0] stream;
  logic [3:0]  flush;
  logic [2:0]  rem;
  logic [4:0]  extra;
  logic [1:0]  base;
  logic [3:0]  new_bits;

  assign cfg_bad = (part_total_i == '0) || (part_total_i > bbqr_pkg::MaxTwoDigit) ||
                   (part_number_i >= part_total_i);

  // Left-align the pending bits and the new byte.
  assign stream = {lo_bits_q, data_byte_i} << (3'd4 - lo_cnt_q);
  assign flush  = lo_bits_q << (3'd4 - lo_cnt_q);

  always_comb begin
    cmd_o      = '0;
    push_o     = 1'b0;
    hdr_done_d = hdr_done_q;
    lo_bits_d  = lo_bits_q;
    lo_cnt_d   = lo_cnt_q;
    rem        = '0;
    extra      = '0;
    base       = '0;
    new_bits   = '0;

    if (lo_cnt_q >= 3'd2) begin
      base     = 2'd2;
      rem      = lo_cnt_q - 3'd2;
      extra    = {stream[1:0], 3'b000};
      new_bits = {2'b00, stream[1:0]} >> (3'd2 - rem);
    end else begin
      base     = 2'd1;
      rem      = lo_cnt_q + 3'd3;
      extra    = stream[6:2];
      new_bits = stream[6:3] >> (3'd4 - rem);
    end

    if (cfg_bad) begin
      cmd_o.err = 1'b1;
      push_o    = 1'b1;
      hdr_done_d = 1'b0;
      lo_bits_d  = '0;
      lo_cnt_d   = '0;
    end else if (empty_part_i) begin
      if (!hdr_done_q) begin
        cmd_o.hdr      = 1'b1;
        cmd_o.hdr_last = 1'b1;
        push_o         = 1'b1;
      end else if (lo_cnt_q != '0) begin
        cmd_o.n_pay    = 2'd1;
        cmd_o.pay[0]   = {flush, 1'b0};
        cmd_o.pay_last = 1'b1;
        push_o         = 1'b1;
      end
      hdr_done_d = 1'b0;
      lo_bits_d  = '0;
      lo_cnt_d   = '0;
    end else begin
      cmd_o.hdr    = !hdr_done_q;
      push_o       = 1'b1;
      cmd_o.pay[0] = stream[11:7];
      cmd_o.pay[1] = stream[6:2];
      cmd_o.n_pay  = base;
      if (last_byte_i) begin
        if (rem != '0) begin
          cmd_o.pay[base] = extra;
          cmd_o.n_pay     = base + 2'd1;
        end
        cmd_o.pay_last = 1'b1;
        hdr_done_d     = 1'b0;
        lo_bits_d      = '0;
        lo_cnt_d       = '0;
      end else begin
        hdr_done_d = 1'b1;
        lo_bits_d  = new_bits;
        lo_cnt_d   = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_done_q <= 1'b0;
      lo_bits_q  <= '0;
      lo_cnt_q   <= '0;
    end else if (accept_i) begin
      hdr_done_q <= hdr_done_d;
      lo_bits_q  <= lo_bits_d;
      lo_cnt_q   <= lo_cnt_d;
    end
  end

endmodule

FILE: src/bbqr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbqr_cmd_fifo: command queue
// Two-entry queue that decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module bbqr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bbqr_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bbqr_pkg::cmd_t cmd_o
);

  bbqr_pkg::cmd_t mem_q [bbqr_pkg::QDepth];
  logic [bbqr_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [bbqr_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == bbqr_pkg::QCntW'(bbqr_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: src/bbqr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbqr_back: character emitter
// Walks one command slot by slot and drives the registered output channel.
// ----------------------------------------------------------------------------
module bbqr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  bbqr_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  input  logic [bbqr_pkg::CodeW-1:0]    encoding_code_i,
  input  logic [bbqr_pkg::CodeW-1:0]    file_type_code_i,
  input  logic [bbqr_pkg::PartW-1:0]    part_total_i,
  input  logic [bbqr_pkg::PartW-1:0]    part_number_i,
  bbqr_out_if.source                    out_o
);

  logic [3:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       err_q, err_d;

  logic [3:0]  pos, last_pos;
  logic        slot_last, step;
  logic [21:0] tot_prod, num_prod;
  logic [5:0]  tot_hi, tot_lo, num_hi, num_lo;
  logic [10:0] tot_rem, num_rem;

  // Base36 digits by reciprocal multiply; valid for values up to 1295.
  assign tot_prod = 22'(part_total_i) * 22'(bbqr_pkg::Recip36);
  assign num_prod = 22'(part_number_i) * 22'(bbqr_pkg::Recip36);
  assign tot_hi   = tot_prod[bbqr_pkg::Recip36Shift +: 6];
  assign num_hi   = num_prod[bbqr_pkg::Recip36Shift +: 6];
  assign tot_rem  = part_total_i - 11'({5'b0, tot_hi} * bbqr_pkg::Base36);
  assign num_rem  = part_number_i - 11'({5'b0, num_hi} * bbqr_pkg::Base36);
  assign tot_lo   = tot_rem[5:0];
  assign num_lo   = num_rem[5:0];

  assign pos       = cmd_i.hdr ? idx_q : idx_q + bbqr_pkg::PosPay0;
  assign last_pos  = bbqr_pkg::PosNumberLo + {2'b00, cmd_i.n_pay};
  assign slot_last = cmd_i.err || (pos == last_pos);
  assign step      = cmd_valid_i && (!valid_q || out_o.ready);
  assign pop_o     = step && slot_last;

  always_comb begin
    unique case (pos)
      bbqr_pkg::PosB:        char_d = bbqr_pkg::CharB;
      bbqr_pkg::PosDollar:   char_d = bbqr_pkg::CharDollar;
      bbqr_pkg::PosEncoding: char_d = encoding_code_i;
      bbqr_pkg::PosFileType: char_d = file_type_code_i;
      bbqr_pkg::PosTotalHi:  char_d = bbqr_pkg::b36_char(tot_hi);
      bbqr_pkg::PosTotalLo:  char_d = bbqr_pkg::b36_char(tot_lo);
      bbqr_pkg::PosNumberHi: char_d = bbqr_pkg::b36_char(num_hi);
      bbqr_pkg::PosNumberLo: char_d = bbqr_pkg::b36_char(num_lo);
      bbqr_pkg::PosPay0:     char_d = bbqr_pkg::b32_char(cmd_i.pay[0]);
      bbqr_pkg::PosPay1:     char_d = bbqr_pkg::b32_char(cmd_i.pay[1]);
      bbqr_pkg::PosPay2:     char_d = bbqr_pkg::b32_char(cmd_i.pay[2]);
      default:               char_d = '0;
    endcase
    if (cmd_i.err) begin
      char_d = '0;
    end
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    last_d  = last_q;
    err_d   = err_q;
    if (step) begin
      valid_d = 1'b1;
      err_d   = cmd_i.err;
      last_d  = cmd_i.err || (slot_last && (cmd_i.hdr_last || cmd_i.pay_last));
      idx_d   = slot_last ? '0 : idx_q + 4'd1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      char_q <= char_d;
    end
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_char  = char_q;
  assign out_o.last_char = last_q;
  assign out_o.error     = err_q;

endmodule

FILE: src/bbqr_part_base32_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbqr_part_base32_framer_top: framer for one part of a multi-part QR payload
// Turns raw part bytes into header plus unpadded base32 characters.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one payload byte per item, with last_byte on the final byte
//   and empty_part to close a part without a byte. out_o carries one ASCII
//   character per item; last_char marks the end of a part, and error marks
//   the single result given for each item while the numbering is invalid.
//   The config port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes encoding code,
//   file-type code, part total and part number; write only while idle.
// Path: the first character of an item is written into the command queue and
//   then the output register, when the queue is empty and out_o is ready.
// Throughput: one character per cycle from the output register while out_o
//   is ready. A byte yields one or two characters (1.6 on average), one more
//   on a last byte with bits left over, plus 8 header characters at the start
//   of a part; the emitter's one-character-per-cycle slot walk sets the pace.
// Reset: config returns to encoding '2', file type 'U', total 1, number 0;
//   the part state and the two-entry command queue are emptied.
// Stall: while out_o is not ready the output register holds; the queue
//   keeps taking items until both entries are full, then in_i.ready drops.
// ----------------------------------------------------------------------------
module bbqr_part_base32_framer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bbqr_in_if.sink                         in_i,
  bbqr_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [bbqr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bbqr_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  logic [bbqr_pkg::CodeW-1:0] encoding_q, file_type_q;
  logic [bbqr_pkg::PartW-1:0] total_q, number_q;

  logic           accept, push, fifo_full, fifo_valid, pop;
  bbqr_pkg::cmd_t front_cmd, head_cmd;

  // Config registers: write whole, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoding_q  <= bbqr_pkg::EncodingReset;
      file_type_q <= bbqr_pkg::FileTypeReset;
      total_q     <= bbqr_pkg::TotalReset;
      number_q    <= bbqr_pkg::NumberReset;
    end else if (cfg_we_i) begin
      unique case (bbqr_pkg::cfg_idx_e'(cfg_idx_i))
        bbqr_pkg::CFG_ENCODING:    encoding_q  <= cfg_wdata_i[bbqr_pkg::CodeW-1:0];
        bbqr_pkg::CFG_FILE_TYPE:   file_type_q <= cfg_wdata_i[bbqr_pkg::CodeW-1:0];
        bbqr_pkg::CFG_PART_TOTAL:  total_q     <= cfg_wdata_i[bbqr_pkg::PartW-1:0];
        bbqr_pkg::CFG_PART_NUMBER: number_q    <= cfg_wdata_i[bbqr_pkg::PartW-1:0];
        default: ;
      endcase
    end
  end

  // Take an item whenever the queue has room.
  assign in_i.ready = !fifo_full;
  assign accept     = in_i.valid && in_i.ready;

  bbqr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .last_byte_i   (in_i.last_byte),
    .empty_part_i  (in_i.empty_part),
    .part_total_i  (total_q),
    .part_number_i (number_q),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  bbqr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && accept),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .cmd_o   (head_cmd)
  );

  bbqr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (fifo_valid),
    .cmd_i            (head_cmd),
    .pop_o            (pop),
    .encoding_code_i  (encoding_q),
    .file_type_code_i (file_type_q),
    .part_total_i     (total_q),
    .part_number_i    (number_q),
    .out_o            (out_o)
  );

endmodule

FILE: tb/bbqr_part_base32_framer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbqr_part_base32_framer_top_tb: self-checking bench for the part framer
// Feeds raw part bytes through the valid/ready byte channel under random
// back-pressure, predicts the header and base32 characters in a scoreboard,
// and compares every character taken from the output channel in order.
// ----------------------------------------------------------------------------
module bbqr_part_base32_framer_top_tb;
  import bbqr_pkg::*;

  // One framed character as the output channel carries it.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } frame_char_t;

  // Scoreboard: own copy of the registers and part state, a queue of the
  // characters still owed by the block, and the compare on each result.
  class framer_scoreboard;
    string       base32_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    string       base36_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    logic [7:0]  enc_code;
    logic [7:0]  ftype_code;
    logic [10:0] total;
    logic [10:0] number;
    bit          hdr_sent;
    int unsigned spare_bits;
    int unsigned spare_cnt;
    frame_char_t expected_chars[$];
    int unsigned mismatches;
    int unsigned chars_checked;
    int unsigned error_results;
    int unsigned parts_closed;

    function new();
      enc_code   = EncodingReset;
      ftype_code = FileTypeReset;
      total      = TotalReset;
      number     = NumberReset;
      clear_part();
    endfunction

    function void clear_part();
      hdr_sent   = 1'b0;
      spare_bits = 0;
      spare_cnt  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [10:0] val);
      case (idx)
        CFG_ENCODING:    enc_code   = val[7:0];
        CFG_FILE_TYPE:   ftype_code = val[7:0];
        CFG_PART_TOTAL:  total      = val;
        CFG_PART_NUMBER: number     = val;
        default: ;
      endcase
    endfunction

    function frame_char_t b32(int unsigned sym);
      frame_char_t c;
      c.ch   = base32_set.getc(sym & 32'h1f);
      c.last = 1'b0;
      c.err  = 1'b0;
      return c;
    endfunction

    // Work out every character one accepted item causes and queue them.
    function void note_item(logic [7:0] data, logic last, logic empty);
      frame_char_t burst[$];
      frame_char_t c;
      int unsigned acc;
      int unsigned cnt;
      if (total == 0 || total > MaxTwoDigit || number >= total) begin
        // bad numbering: one error character per item, part state dropped
        clear_part();
        c.ch   = 8'h00;
        c.last = 1'b1;
        c.err  = 1'b1;
        expected_chars.push_back(c);
        return;
      end
      if (!hdr_sent) begin
        c.last = 1'b0;
        c.err  = 1'b0;
        c.ch = "B";                                  burst.push_back(c);
        c.ch = "$";                                  burst.push_back(c);
        c.ch = enc_code;                             burst.push_back(c);
        c.ch = ftype_code;                           burst.push_back(c);
        c.ch = base36_set.getc((total / 36) % 36);   burst.push_back(c);
        c.ch = base36_set.getc(total % 36);          burst.push_back(c);
        c.ch = base36_set.getc((number / 36) % 36);  burst.push_back(c);
        c.ch = base36_set.getc(number % 36);         burst.push_back(c);
        hdr_sent = 1'b1;
        if (empty) begin
          burst[burst.size()-1].last = 1'b1;
          clear_part();
          expected_chars = {expected_chars, burst};
          parts_closed++;
          return;
        end
      end else if (empty) begin
        // close the part without a byte: flush any spare bits, else nothing
        if (spare_cnt > 0) begin
          c = b32(spare_bits << (5 - spare_cnt));
          c.last = 1'b1;
          expected_chars.push_back(c);
        end
        clear_part();
        parts_closed++;
        return;
      end
      acc = (spare_bits << 8) | data;
      cnt = spare_cnt + 8;
      while (cnt >= 5) begin
        cnt -= 5;
        burst.push_back(b32(acc >> cnt));
      end
      acc &= (1 << cnt) - 1;
      if (last) begin
        if (cnt > 0) burst.push_back(b32(acc << (5 - cnt)));
        burst[burst.size()-1].last = 1'b1;
        clear_part();
        parts_closed++;
      end else begin
        spare_bits = acc;
        spare_cnt  = cnt;
      end
      expected_chars = {expected_chars, burst};
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    // Compare one accepted character with the oldest one owed.
    function void check_result(logic [7:0] ch, logic last, logic err);
      frame_char_t want;
      chars_checked++;
      if (err) error_results++;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last %0b error %0b", ch, last, err));
        return;
      end
      want = expected_chars.pop_front();
      if (want.ch !== ch || want.last !== last || want.err !== err) begin
        report($sformatf("char exp 0x%02h got 0x%02h, last exp %0b got %0b, error exp %0b got %0b",
                         want.ch, ch, want.last, last, want.err, err));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  bbqr_in_if  in_if ();
  bbqr_out_if out_if ();

  framer_scoreboard sb = new();

  bit          bursts_on = 1'b1;  // random idling on both channels
  int unsigned items_sent;
  int unsigned settings_used;

  bbqr_part_base32_framer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block stops moving items.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Output side: hold ready low in random bursts.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Check every character taken at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.out_char, out_if.last_char, out_if.error);
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high
  // afterwards so that back-to-back items need no extra assignment.
  task automatic send_item(input logic [7:0] data, input logic last, input logic empty);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= data;
    in_if.last_byte  <= last;
    in_if.empty_part <= empty;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(data, last, empty);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every owed character has arrived, then give
  // the pipeline time to finish items that cause no character at all.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // Write one register; the block must be idle. Drop the write enable before
  // returning so the next write starts on a fresh falling edge.
  task automatic write_cfg(input cfg_idx_e idx, input logic [10:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic write_all(input logic [10:0] enc, input logic [10:0] ftype,
                           input logic [10:0] tot, input logic [10:0] num);
    write_cfg(CFG_ENCODING, enc);
    write_cfg(CFG_FILE_TYPE, ftype);
    write_cfg(CFG_PART_TOTAL, tot);
    write_cfg(CFG_PART_NUMBER, num);
    settings_used++;
  endtask

  // One well-formed part: len bytes, closed by a last mark on the final
  // byte, or by a trailing empty item when close_by_empty is set or len is zero.
  task automatic send_part(input int unsigned len, input bit close_by_empty);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), !close_by_empty && (i == len - 1), 1'b0);
    end
    if (len == 0 || close_by_empty) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned len;
    logic [10:0] tot;
    logic [10:0] num;
    int unsigned pick;

    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.last_byte  = 1'b0;
    in_if.empty_part = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_ENCODING;
    cfg_wdata_i      = '0;
    rst_ni           = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed: reset settings, encoding '2', file type 'U', part 0 of 1
    // empty part before any byte: header only, last on its final char
    send_item(8'h00, 1'b0, 1'b1);
    // single zero byte ends the part: header, then two chars
    send_item(8'h00, 1'b1, 1'b0);
    // all-ones byte leaves three bits; the empty item flushes them padded
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // five bytes fill 40 bits exactly: no padding char on the last byte
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h81, 1'b1, 1'b0);
    // five bytes then an empty item: nothing left over, nothing emitted
    send_item(8'h12, 1'b0, 1'b0);
    send_item(8'h34, 1'b0, 1'b0);
    send_item(8'h56, 1'b0, 1'b0);
    send_item(8'h78, 1'b0, 1'b0);
    send_item(8'h9A, 1'b0, 1'b0);
    send_item(8'hBC, 1'b0, 1'b1);
    // empty mark wins over last mark: header only
    send_item(8'h3C, 1'b1, 1'b1);
    // empty and last together after the header: flush only
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    settle();

    // extremes of the header fields; upper data bits of the codes ignored
    write_all(11'h700, 11'h0FF, 11'd1295, 11'd1294);
    send_item(8'h0F, 1'b0, 1'b0);
    send_item(8'hF0, 1'b1, 1'b0);
    settle();
    write_all(11'h0FF, 11'h000, 11'd1295, 11'd0);
    send_item(8'h55, 1'b1, 1'b0);
    settle();

    // bad numbering: total above two base36 digits, zero, number too big
    write_cfg(CFG_PART_TOTAL, 11'd1296);
    send_item(8'hAA, 1'b1, 1'b0);
    settle();
    write_all(11'd66, 11'd84, 11'd0, 11'd0);
    send_item(8'h01, 1'b0, 1'b0);
    settle();
    write_all(11'd66, 11'd84, 11'd2047, 11'd2047);
    send_item(8'h02, 1'b0, 1'b1);
    settle();
    write_all(11'd66, 11'd84, 11'd5, 11'd5);
    send_item(8'h03, 1'b1, 1'b0);
    settle();

    // an error item drops a half-built part: the next byte starts a header
    write_all(11'd48, 11'd80, 11'd36, 11'd35);
    send_item(8'hE7, 1'b0, 1'b0);
    settle();
    write_cfg(CFG_PART_TOTAL, 11'd0);
    send_item(8'h00, 1'b0, 1'b0);
    settle();
    write_cfg(CFG_PART_TOTAL, 11'd36);
    send_item(8'h00, 1'b1, 1'b0);
    settle();

    // ---- random phases: a fresh setting each, mostly well-formed parts
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 9) bursts_on = 1'b0;  // last stretch runs flat out
      pick = (phase == 0 || phase == 9) ? 11 : $urandom_range(0, 11);
      case (pick)
        0: begin
          tot = 11'd0;
          num = 11'($urandom_range(0, 2047));
        end
        1: begin
          tot = 11'($urandom_range(1296, 2047));
          num = 11'($urandom_range(0, 2047));
        end
        2: begin
          tot = 11'($urandom_range(1, 1295));
          num = 11'($urandom_range(tot, 2047));
        end
        3, 4: begin
          tot = 11'($urandom_range(1, 36));
          num = 11'($urandom_range(0, tot - 1));
        end
        default: begin
          tot = 11'($urandom_range(1, 1295));
          num = 11'($urandom_range(0, tot - 1));
        end
      endcase
      write_all(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), tot, num);
      phase_items = items_sent + 30;
      while (items_sent < phase_items) begin
        if ($urandom_range(0, 5) == 0) begin
          // noise: any mix of marks and data
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end else begin
          len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
          send_part(len, $urandom_range(0, 7) == 0);
        end
        // in phase 3, hold the sender until the block has delivered everything
        if (phase == 3 && items_sent >= phase_items - 16 && items_sent < phase_items - 8) begin
          settle();
        end
      end
      settle();
    end

    repeat (20) @(posedge clk_i);

    $display("Covered %0d items over %0d register settings: %0d chars checked, %0d parts closed,",
             items_sent, settings_used, sb.chars_checked, sb.parts_closed);
    $display("%0d error results, %0d mismatches, %0d chars still owed.",
             sb.error_results, sb.mismatches, sb.expected_chars.size());
    if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/bbqr_pkg.sv
src/bbqr_in_if.sv
src/bbqr_out_if.sv
src/bbqr_front.sv
src/bbqr_cmd_fifo.sv
src/bbqr_back.sv
src/bbqr_part_base32_framer_top.sv
tb/bbqr_part_base32_framer_top_tb.sv
